[rtl/mlet_pkg.sv]
// Shared types and constants for the min line envelope tree.
// Used by mlet_cell and min_line_envelope_tree_top.
package mlet_pkg;

  localparam int DOMAIN_BITS_DEF = 10;
  localparam int XW = 34;   // x coordinates, lo/hi/mid with headroom
  localparam int PW = 66;   // 32 x 34 product plus intercept

  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_QUERY  = 1'b1;

  localparam logic [1:0] REG_DOMAIN_LOW  = 2'd0;
  localparam logic [1:0] REG_DOMAIN_HIGH = 2'd1;
  localparam logic [1:0] REG_EMPTY_VALUE = 2'd2;

  // one item in flight between tree levels
  typedef struct packed {
    logic                 op;
    logic signed [31:0]   a;
    logic signed [31:0]   b;
    logic signed [31:0]   x;
    logic signed [XW-1:0] lo;
    logic signed [XW-1:0] hi;
    logic signed [63:0]   best;
    logic                 found;
    logic                 done;
  } mlet_item_t;

endpackage

[rtl/mlet_ram.sv]
// Generic single write port RAM with registered read.
// No dependencies.
module mlet_ram #(
  parameter int W     = 8,
  parameter int DEPTH = 2
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [W-1:0]             wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [W-1:0]             rdata
);

  logic [W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end

endmodule

[rtl/mlet_cell.sv]
// One tree level: node store for this level plus the per-node insert/query step.
// Depends on mlet_pkg and mlet_ram.
module mlet_cell #(
  parameter int LEVEL = 0,
  parameter int IW    = 10
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 clr,
  input  logic [IW-1:0]        clr_addr,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  mlet_pkg::mlet_item_t in_item,
  input  logic [IW-1:0]        in_idx,
  output logic                 out_valid,
  input  logic                 out_ready,
  output mlet_pkg::mlet_item_t out_item,
  output logic [IW-1:0]        out_idx
);
  import mlet_pkg::*;

  localparam int AW    = (LEVEL == 0) ? 1 : LEVEL;
  localparam int DEPTH = 1 << AW;
  localparam int DW    = 65;

  typedef enum logic [2:0] {S_IDLE, S_READ, S_LOAD, S_EVAL, S_DECIDE, S_OUT} state_t;

  state_t             state;
  mlet_item_t         it;
  logic [IW-1:0]      idx;
  logic signed [31:0] sa, sb;
  logic               su;
  logic [2:0]         step;
  logic               ph;
  logic [PW-1:0]      prod;
  logic signed [PW-1:0] v [6];
  logic signed [XW-1:0] mid;

  logic [DW-1:0]      rdata;
  logic               wr_new;
  logic               ram_we;
  logic [AW-1:0]      ram_waddr;
  logic [DW-1:0]      ram_wdata;

  // midpoint, truncated toward zero
  logic signed [XW:0]   sum_c;
  logic signed [XW:0]   sum_adj;
  logic signed [XW-1:0] mid_c;
  assign sum_c   = {it.lo[XW-1], it.lo} + {it.hi[XW-1], it.hi};
  assign sum_adj = sum_c + {{XW{1'b0}}, sum_c[XW]};
  assign mid_c   = XW'(sum_adj >>> 1);

  // shared multiplier operands
  logic signed [31:0]   m_a, m_b;
  logic signed [XW-1:0] m_x;
  logic [PW-1:0]        prod_c;
  always_comb begin
    m_a = step[0] ? it.a : sa;
    m_b = step[0] ? it.b : sb;
    if (it.op == OP_QUERY) m_x = {{(XW-32){it.x[31]}}, it.x};
    else if (step < 3'd2)  m_x = it.lo;
    else if (step < 3'd4)  m_x = it.hi;
    else                   m_x = mid;
  end
  assign prod_c = {{(PW-32){m_a[31]}}, m_a} * {{(PW-XW){m_x[XW-1]}}, m_x};

  logic [2:0] last_step;
  assign last_step = (it.op == OP_QUERY) ? 3'd0 : 3'd5;

  // node decision
  mlet_item_t   nxt;
  logic         dir;
  logic         swap;
  logic signed [PW-1:0] lo_keep, lo_move;
  logic signed [63:0]   qv;
  always_comb begin
    nxt     = it;
    dir     = 1'b0;
    wr_new  = 1'b0;
    swap    = 1'b0;
    lo_keep = v[0];
    lo_move = v[1];
    qv      = v[0][63:0];
    if (!su) begin
      nxt.done = 1'b1;
      wr_new   = (it.op == OP_INSERT);
    end else if (it.op == OP_QUERY) begin
      if (!it.found || qv < it.best) nxt.best = qv;
      nxt.found = 1'b1;
      if (it.lo >= it.hi) begin
        nxt.done = 1'b1;
      end else begin
        dir = ($signed({{(XW-32){it.x[31]}}, it.x}) > mid);
        if (dir) nxt.lo = mid + XW'(1);
        else     nxt.hi = mid;
      end
    end else if (v[0] <= v[1] && v[2] <= v[3]) begin
      nxt.done = 1'b1;   // stored line no worse anywhere: drop new one
    end else if (v[0] >= v[1] && v[2] >= v[3]) begin
      nxt.done = 1'b1;   // new line dominates
      wr_new   = 1'b1;
    end else begin
      swap   = v[4] > v[5];
      wr_new = swap;
      if (swap) begin
        lo_keep = v[1];
        lo_move = v[0];
        nxt.a   = sa;
        nxt.b   = sb;
      end
      dir = !(lo_keep >= lo_move);
      if (dir) nxt.lo = mid + XW'(1);
      else     nxt.hi = mid;
    end
  end

  assign ram_we    = clr || (state == S_DECIDE && wr_new);
  assign ram_waddr = clr ? clr_addr[AW-1:0] : idx[AW-1:0];
  assign ram_wdata = clr ? '0 : {1'b1, it.a, it.b};

  mlet_ram #(.W(DW), .DEPTH(DEPTH)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (idx[AW-1:0]),
    .rdata (rdata)
  );

  assign in_ready  = (state == S_IDLE) && !clr;
  assign out_valid = (state == S_OUT);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (in_valid && !clr) begin
            it    <= in_item;
            idx   <= in_idx;
            state <= in_item.done ? S_OUT : S_READ;
            // finished walk: pass the item straight on
            if (in_item.done) begin
              out_item <= in_item;
              out_idx  <= in_idx;
            end
          end
        end
        S_READ: begin
          mid   <= mid_c;
          state <= S_LOAD;
        end
        S_LOAD: begin
          su    <= rdata[DW-1];
          sa    <= rdata[63:32];
          sb    <= rdata[31:0];
          step  <= 3'd0;
          ph    <= 1'b0;
          state <= rdata[DW-1] ? S_EVAL : S_DECIDE;
        end
        S_EVAL: begin
          if (!ph) begin
            prod <= prod_c;
            ph   <= 1'b1;
          end else begin
            v[step] <= prod + {{(PW-32){m_b[31]}}, m_b};
            ph      <= 1'b0;
            if (step == last_step) state <= S_DECIDE;
            else                   step  <= step + 3'd1;
          end
        end
        S_DECIDE: begin
          out_item <= nxt;
          out_idx  <= IW'({idx, dir});
          state    <= S_OUT;
        end
        S_OUT: begin
          if (out_ready) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

[rtl/min_line_envelope_tree_top.sv]
// Top level of the min line envelope tree: config registers, span setup,
// chain of level cells, clearing pass and output register. Uses mlet_pkg, mlet_cell.
// Usage:
//   Input channel (in_valid/in_stall) carries opcode, slope, intercept, point.
//   opcode insert stores a line; opcode query returns one min_value transfer
//   on the output channel (out_valid/out_stall). Inserts return nothing.
//   Config is written through cfg_we/cfg_index/cfg_data while the block is idle.
// Levels and evaluation:
//   The item walks DOMAIN_BITS+1 level cells. A level holding a line makes one
//   evaluation for a query and six for an insert, on one shared 32x34
//   multiplier; an empty node needs none, and a finished walk is passed straight on.
//   Each level holds one item at a time and takes its next item only after
//   it has handed the last one on to the next level.
// Reset:
//   rst clears control state and starts a clearing pass that walks all
//   2^DOMAIN_BITS addresses of the node stores, with in_stall held high during it.
// Stall:
//   While out_stall is high the result holds; items behind it back up level
//   by level until in_stall rises.
module min_line_envelope_tree_top #(
  parameter int DOMAIN_BITS = mlet_pkg::DOMAIN_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        opcode,
  input  logic signed [31:0] slope,
  input  logic signed [31:0] intercept,
  input  logic signed [31:0] point,
  output logic        out_valid,
  input  logic        out_stall,
  output logic signed [63:0] min_value,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [63:0] cfg_data
);
  import mlet_pkg::*;

  localparam int NL = DOMAIN_BITS + 1;
  localparam int IW = DOMAIN_BITS;

  logic signed [31:0] domain_low, domain_high;
  logic signed [63:0] empty_value;

  always_ff @(posedge clk) begin
    if (rst) begin
      domain_low  <= 32'sd0;
      domain_high <= 32'sd1023;
      empty_value <= 64'sh4000_0000_0000_0000;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_DOMAIN_LOW:  domain_low  <= cfg_data[31:0];
        REG_DOMAIN_HIGH: domain_high <= cfg_data[31:0];
        REG_EMPTY_VALUE: empty_value <= cfg_data;
        default: ;
      endcase
    end
  end

  // clearing pass
  logic          clearing;
  logic [IW-1:0] clr_cnt;
  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_cnt  <= '0;
    end else if (clearing) begin
      clr_cnt <= clr_cnt + IW'(1);
      if (&clr_cnt) clearing <= 1'b0;
    end
  end

  // covered span
  logic signed [XW-1:0] span_lo, span_cap, span_hi_dh, span_hi;
  always_comb begin
    span_lo    = {{(XW-32){domain_low[31]}}, domain_low};
    span_cap   = span_lo + (XW'(1) << DOMAIN_BITS) - XW'(1);
    span_hi_dh = {{(XW-32){domain_high[31]}}, domain_high};
    span_hi    = (span_hi_dh > span_cap) ? span_cap : span_hi_dh;
    if (span_hi < span_lo) span_hi = span_lo;
  end

  mlet_item_t first_item;
  always_comb begin
    first_item       = '0;
    first_item.op    = opcode;
    first_item.a     = slope;
    first_item.b     = intercept;
    first_item.x     = point;
    first_item.lo    = span_lo;
    first_item.hi    = span_hi;
    first_item.found = 1'b0;
    first_item.done  = 1'b0;
  end

  mlet_item_t    ch_item  [NL+1];
  logic [IW-1:0] ch_idx   [NL+1];
  logic          ch_valid [NL+1];
  logic          ch_ready [NL+1];

  assign ch_item[0]  = first_item;
  assign ch_idx[0]   = '0;
  assign ch_valid[0] = in_valid;
  assign in_stall    = !ch_ready[0];

  for (genvar k = 0; k < NL; k++) begin : g_lvl
    mlet_cell #(.LEVEL(k), .IW(IW)) u_cell (
      .clk       (clk),
      .rst       (rst),
      .clr       (clearing),
      .clr_addr  (clr_cnt),
      .in_valid  (ch_valid[k]),
      .in_ready  (ch_ready[k]),
      .in_item   (ch_item[k]),
      .in_idx    (ch_idx[k]),
      .out_valid (ch_valid[k+1]),
      .out_ready (ch_ready[k+1]),
      .out_item  (ch_item[k+1]),
      .out_idx   (ch_idx[k+1])
    );
  end

  // output register
  assign ch_ready[NL] = !out_valid || !out_stall;
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      if (out_valid && !out_stall) out_valid <= 1'b0;
      if (ch_valid[NL] && ch_ready[NL] && ch_item[NL].op == OP_QUERY) begin
        out_valid <= 1'b1;
        min_value <= ch_item[NL].found ? ch_item[NL].best : empty_value;
      end
    end
  end

endmodule

[rtl/mlet_checker.sv]
// Port-level checks for the min line envelope tree, bound to the top level.
// Depends on min_line_envelope_tree_top port names only.
module mlet_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [63:0] min_value
);

  // reset empties the output register
  a_rst_out: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("out_valid after reset");

  // clearing pass blocks input right after reset
  a_rst_stall: assert property (@(posedge clk) rst |=> in_stall)
    else $error("input taken during clearing pass");

  // handshake outputs are always known out of reset
  a_known: assert property (@(posedge clk) disable iff (rst)
      !$isunknown({in_stall, out_valid}))
    else $error("handshake output unknown");

  a_hold: assert property (@(posedge clk) disable iff (rst)
      (out_valid && out_stall) |=> (out_valid && $stable(min_value)))
    else $error("stalled result changed");

endmodule

bind min_line_envelope_tree_top mlet_checker u_mlet_checker (.*);
